// ===== rtl/prce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline relative-coordinate encoder package
// Shared types and constants for the encoder's step logic and top level.
// ----------------------------------------------------------------------------
package prce_pkg;

   // Coordinate and byte widths.
   localparam int COORD_W  = 12;
   localparam int BYTE_W   = 8;
   localparam int RUN_MAX  = 7;
   localparam int COUNT_W  = 3;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address bits [3:2]).
   localparam logic [1:0] REG_SHORT_OPCODE  = 2'd0;
   localparam logic [1:0] REG_MEDIUM_OPCODE = 2'd1;
   localparam logic [1:0] REG_LONG_OPCODE   = 2'd2;

   // Register reset values.
   localparam logic [BYTE_W-1:0] SHORT_OPCODE_RESET  = 8'd247;
   localparam logic [BYTE_W-1:0] MEDIUM_OPCODE_RESET = 8'd245;
   localparam logic [BYTE_W-1:0] LONG_OPCODE_RESET   = 8'd246;

   // Mode thresholds.
   localparam logic [COORD_W-1:0]   SHORT_LIMIT  = 12'd7;
   localparam logic [COORD_W-1:0]   MEDIUM_LIMIT = 12'd128;
   localparam logic signed [12:0]   MEDIUM_DY_MIN = -13'sd111;

   // Segment coordinate modes.
   typedef enum logic [1:0] {
      MODE_SHORT  = 2'd0,
      MODE_MEDIUM = 2'd1,
      MODE_LONG   = 2'd2
   } mode_type;

   // Bytes produced by one point, byte 0 goes out first.
   typedef struct packed {
      logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
      logic [COUNT_W-1:0]             count;
      logic                           head_op;
   } run_type;

endpackage

// ===== rtl/prce_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline encoder step logic
// Picks the coordinate mode for one step and builds the full byte run for it.
// ----------------------------------------------------------------------------
module prce_step (
   input  logic [prce_pkg::COORD_W-1:0] point_x,
   input  logic [prce_pkg::COORD_W-1:0] point_y,
   input  logic                         starts_polyline,
   input  logic [prce_pkg::COORD_W-1:0] prev_x,
   input  logic [prce_pkg::COORD_W-1:0] prev_y,
   input  logic                         have_previous,
   input  logic                         segment_open,
   input  prce_pkg::mode_type           segment_mode,
   input  logic [prce_pkg::BYTE_W-1:0]  short_opcode,
   input  logic [prce_pkg::BYTE_W-1:0]  medium_opcode,
   input  logic [prce_pkg::BYTE_W-1:0]  long_opcode,
   output prce_pkg::mode_type           step_mode,
   output logic                         lone_point,
   output prce_pkg::run_type            run
);

   logic signed [12:0]                 dx;
   logic signed [12:0]                 dy;
   logic [prce_pkg::COORD_W-1:0]       adx;
   logic [prce_pkg::COORD_W-1:0]       ady;
   logic [prce_pkg::COORD_W-1:0]       span;
   logic                               opening;
   logic [prce_pkg::BYTE_W-1:0]        opcode;
   logic [3:0][prce_pkg::BYTE_W-1:0]   hdr;
   logic [2:0][prce_pkg::BYTE_W-1:0]   data;
   logic [1:0]                         data_n;

   // Step distances.
   assign dx   = $signed({1'b0, point_x}) - $signed({1'b0, prev_x});
   assign dy   = $signed({1'b0, point_y}) - $signed({1'b0, prev_y});
   assign adx  = dx[12] ? 12'(-dx) : dx[11:0];
   assign ady  = dy[12] ? 12'(-dy) : dy[11:0];
   assign span = (adx > ady) ? adx : ady;

   // Mode choice.
   always_comb begin
      if (span < prce_pkg::SHORT_LIMIT) begin
         step_mode = prce_pkg::MODE_SHORT;
      end else if ((dy > prce_pkg::MEDIUM_DY_MIN) && (span < prce_pkg::MEDIUM_LIMIT)) begin
         step_mode = prce_pkg::MODE_MEDIUM;
      end else begin
         step_mode = prce_pkg::MODE_LONG;
      end
   end

   assign lone_point = starts_polyline || !have_previous;
   assign opening    = !segment_open || (step_mode != segment_mode);

   // Opcode and header with the previous point's absolute coordinate.
   always_comb begin
      unique case (step_mode)
         prce_pkg::MODE_SHORT:  opcode = short_opcode;
         prce_pkg::MODE_MEDIUM: opcode = medium_opcode;
         default:               opcode = long_opcode;
      endcase
   end

   assign hdr[0] = opcode;
   assign hdr[1] = {prev_x[11:8], prev_y[11:8]};
   assign hdr[2] = prev_x[7:0];
   assign hdr[3] = prev_y[7:0];

   // Step data for the chosen mode.
   always_comb begin
      unique case (step_mode)
         prce_pkg::MODE_SHORT: begin
            data[0] = {dx[12], adx[2:0], dy[12], ady[2:0]};
            data[1] = '0;
            data[2] = '0;
            data_n  = 2'd1;
         end
         prce_pkg::MODE_MEDIUM: begin
            data[0] = {dy[12], ady[6:0]};
            data[1] = dx[7:0];
            data[2] = '0;
            data_n  = 2'd2;
         end
         default: begin
            data[0] = {point_x[11:8], point_y[11:8]};
            data[1] = point_x[7:0];
            data[2] = point_y[7:0];
            data_n  = 2'd3;
         end
      endcase
   end

   // Assemble the run; a lone point gives no bytes.
   always_comb begin
      run.head_op = opening;
      if (opening) begin
         run.bytes = {data[2], data[1], data[0], hdr[3], hdr[2], hdr[1], hdr[0]};
         run.count = 3'd4 + {1'b0, data_n};
      end else begin
         run.bytes = {32'h0, data[2], data[1], data[0]};
         run.count = {1'b0, data_n};
      end
      if (lone_point) begin
         run.count = '0;
      end
   end

endmodule

// ===== rtl/polyline_relative_coord_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline relative-coordinate encoder
// Turns a stream of polyline points into a byte stream of segment opcodes,
// absolute coordinates and short, medium or long relative steps.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Word
//   req_      in         req_valid/req_ready  point_x, point_y, starts_polyline
//   rsp_      out        rsp_valid/rsp_ready  out_byte, is_opcode, last_of_run
//   csr_      in/out     APB, pready high     three 8-bit opcode registers
//
// A point is encoded in the cycle it is accepted and its run of 0 to 7 bytes is
// held in a run register, which the output register drains at one byte a cycle
// while rsp_ready allows it; the output byte rate sets the throughput.
// A new point is taken as the last byte of the previous run moves out.
// Reset is synchronous and restores the opcode defaults; a stalled rsp_ready
// holds the output word and backs up into req_ready.
// ----------------------------------------------------------------------------
module polyline_relative_coord_encoder_top (
   input  logic                            clock,
   input  logic                            reset,
   // Point input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [prce_pkg::COORD_W-1:0]    req_point_x,
   input  logic [prce_pkg::COORD_W-1:0]    req_point_y,
   input  logic                            req_starts_polyline,
   // Byte output
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [prce_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                            rsp_is_opcode,
   output logic                            rsp_last_of_run,
   // Configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prce_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [prce_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [prce_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   // Opcode registers.
   logic [prce_pkg::BYTE_W-1:0] short_op_ff, short_op_in;
   logic [prce_pkg::BYTE_W-1:0] medium_op_ff, medium_op_in;
   logic [prce_pkg::BYTE_W-1:0] long_op_ff, long_op_in;

   // Encoder state.
   logic [prce_pkg::COORD_W-1:0] prev_x_ff, prev_x_in;
   logic [prce_pkg::COORD_W-1:0] prev_y_ff, prev_y_in;
   logic                         have_prev_ff, have_prev_in;
   logic                         seg_open_ff, seg_open_in;
   prce_pkg::mode_type           seg_mode_ff, seg_mode_in;

   // Run register.
   logic [prce_pkg::RUN_MAX-1:0][prce_pkg::BYTE_W-1:0] run_bytes_ff, run_bytes_in;
   logic [prce_pkg::COUNT_W-1:0] run_cnt_ff, run_cnt_in;
   logic                         run_op_ff, run_op_in;

   // Output register.
   logic                         out_valid_ff, out_valid_in;
   logic [prce_pkg::BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic                         out_op_ff, out_op_in;
   logic                         out_last_ff, out_last_in;

   logic                         csr_write;
   logic                         req_fire;
   logic                         move;
   prce_pkg::mode_type           step_mode;
   logic                         lone_point;
   prce_pkg::run_type            step_run;

   // Step encoder.
   prce_step u_step (
      .point_x         (req_point_x),
      .point_y         (req_point_y),
      .starts_polyline (req_starts_polyline),
      .prev_x          (prev_x_ff),
      .prev_y          (prev_y_ff),
      .have_previous   (have_prev_ff),
      .segment_open    (seg_open_ff),
      .segment_mode    (seg_mode_ff),
      .short_opcode    (short_op_ff),
      .medium_opcode   (medium_op_ff),
      .long_opcode     (long_op_ff),
      .step_mode       (step_mode),
      .lone_point      (lone_point),
      .run             (step_run)
   );

   // Configuration writes and reads.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      short_op_in  = short_op_ff;
      medium_op_in = medium_op_ff;
      long_op_in   = long_op_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            prce_pkg::REG_SHORT_OPCODE:  short_op_in  = csr_pwdata[7:0];
            prce_pkg::REG_MEDIUM_OPCODE: medium_op_in = csr_pwdata[7:0];
            prce_pkg::REG_LONG_OPCODE:   long_op_in   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         prce_pkg::REG_SHORT_OPCODE:  csr_prdata = {24'h0, short_op_ff};
         prce_pkg::REG_MEDIUM_OPCODE: csr_prdata = {24'h0, medium_op_ff};
         prce_pkg::REG_LONG_OPCODE:   csr_prdata = {24'h0, long_op_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   // Handshakes: a byte moves from the run register when the output slot frees.
   assign move      = (run_cnt_ff != '0) && (!out_valid_ff || rsp_ready);
   assign req_ready = (run_cnt_ff == '0) || ((run_cnt_ff == 3'd1) && move);
   assign req_fire  = req_valid && req_ready;

   // Encoder state update on each accepted point.
   always_comb begin
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      seg_open_in  = seg_open_ff;
      seg_mode_in  = seg_mode_ff;
      if (req_fire) begin
         prev_x_in    = req_point_x;
         prev_y_in    = req_point_y;
         have_prev_in = 1'b1;
         if (lone_point) begin
            seg_open_in = 1'b0;
         end else begin
            seg_open_in = 1'b1;
            seg_mode_in = step_mode;
         end
      end
   end

   // Run register: load a new run or shift out the head byte.
   always_comb begin
      run_bytes_in = run_bytes_ff;
      run_cnt_in   = run_cnt_ff;
      run_op_in    = run_op_ff;
      if (req_fire) begin
         run_bytes_in = step_run.bytes;
         run_cnt_in   = step_run.count;
         run_op_in    = step_run.head_op;
      end else if (move) begin
         run_bytes_in = {8'h0, run_bytes_ff[prce_pkg::RUN_MAX-1:1]};
         run_cnt_in   = run_cnt_ff - 3'd1;
         run_op_in    = 1'b0;
      end
   end

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_op_in    = out_op_ff;
      out_last_in  = out_last_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_byte_in  = run_bytes_ff[0];
         out_op_in    = run_op_ff;
         out_last_in  = (run_cnt_ff == 3'd1);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_is_opcode   = out_op_ff;
   assign rsp_last_of_run = out_last_ff;

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         short_op_ff  <= prce_pkg::SHORT_OPCODE_RESET;
         medium_op_ff <= prce_pkg::MEDIUM_OPCODE_RESET;
         long_op_ff   <= prce_pkg::LONG_OPCODE_RESET;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         seg_open_ff  <= 1'b0;
         seg_mode_ff  <= prce_pkg::MODE_SHORT;
         run_cnt_ff   <= '0;
         run_op_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         short_op_ff  <= short_op_in;
         medium_op_ff <= medium_op_in;
         long_op_ff   <= long_op_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
         seg_open_ff  <= seg_open_in;
         seg_mode_ff  <= seg_mode_in;
         run_cnt_ff   <= run_cnt_in;
         run_op_ff    <= run_op_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      run_bytes_ff <= run_bytes_in;
      out_byte_ff  <= out_byte_in;
      out_op_ff    <= out_op_in;
      out_last_ff  <= out_last_in;
   end

   // Input is only taken when at most one byte of the old run remains.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (run_cnt_ff <= 3'd1))
      else $error("input taken while run register still busy");

   // A point that follows a previous one always leaves bytes to send.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && have_prev_ff && !req_starts_polyline) |=> (run_cnt_ff != '0))
      else $error("non-lone point produced an empty run");

   // Moving the final byte of a run marks it as last.
   assert property (@(posedge clock) disable iff (reset)
      (move && (run_cnt_ff == 3'd1)) |=> (rsp_valid && rsp_last_of_run))
      else $error("final byte of run not flagged as last");

   // An opcode byte is never the end of a run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_opcode) |-> !rsp_last_of_run)
      else $error("opcode byte flagged as last of run");

endmodule

// ===== dv/prce_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline encoder stream checker
// Watches the point, byte and register ports of the encoder. It keeps its own
// copy of the opcode registers and the previous-point state, works out the
// bytes that each accepted point must produce, and compares every byte that
// leaves the block against the oldest byte still owed.
// ----------------------------------------------------------------------------
module prce_stream_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [prce_pkg::COORD_W-1:0]    req_point_x,
   input  logic [prce_pkg::COORD_W-1:0]    req_point_y,
   input  logic                            req_starts_polyline,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [prce_pkg::BYTE_W-1:0]     rsp_out_byte,
   input  logic                            rsp_is_opcode,
   input  logic                            rsp_last_of_run,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prce_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [prce_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,
   output int                              error_count,
   output int                              bytes_pending,
   output int                              points_seen,
   output int                              bytes_checked
);

   // One output word: a byte of the command stream and its two flags.
   typedef struct packed {
      logic [prce_pkg::BYTE_W-1:0] data;
      logic                        opcode;
      logic                        last;
   } stream_word_type;

   stream_word_type   owed_bytes[$];
   stream_word_type   run_buf[prce_pkg::RUN_MAX];
   int                run_len;

   // Shadow of the opcode registers and the encoder state.
   logic [prce_pkg::BYTE_W-1:0]  short_op, medium_op, long_op;
   logic [prce_pkg::COORD_W-1:0] prev_x, prev_y;
   logic                         have_prev;
   logic                         seg_open;
   prce_pkg::mode_type           seg_mode;

   task automatic add_byte(input logic [prce_pkg::BYTE_W-1:0] data, input logic opcode);
      run_buf[run_len] = '{data: data, opcode: opcode, last: 1'b0};
      run_len++;
   endtask

   // Absolute coordinate: high nibbles of x and y, then the two low bytes.
   task automatic add_coord(input logic [prce_pkg::COORD_W-1:0] cx,
                            input logic [prce_pkg::COORD_W-1:0] cy);
      add_byte({cx[11:8], cy[11:8]}, 1'b0);
      add_byte(cx[7:0], 1'b0);
      add_byte(cy[7:0], 1'b0);
   endtask

   // Works out the bytes caused by one point and queues them in order.
   task automatic encode_point(input logic [prce_pkg::COORD_W-1:0] px,
                               input logic [prce_pkg::COORD_W-1:0] py,
                               input logic first);
      int                          dx, dy, adx, ady, span;
      prce_pkg::mode_type          step_mode;
      logic [prce_pkg::BYTE_W-1:0] op, b;
      stream_word_type             w;
      points_seen++;
      run_len = 0;
      // A first point of a polyline is only recorded and closes the segment.
      if (first || !have_prev) begin
         prev_x    = px;
         prev_y    = py;
         have_prev = 1'b1;
         seg_open  = 1'b0;
         return;
      end
      dx   = int'(px) - int'(prev_x);
      dy   = int'(py) - int'(prev_y);
      adx  = (dx < 0) ? -dx : dx;
      ady  = (dy < 0) ? -dy : dy;
      span = (adx > ady) ? adx : ady;
      if (span < 7) begin
         step_mode = prce_pkg::MODE_SHORT;
      end else if (dy > -111 && span < 128) begin
         step_mode = prce_pkg::MODE_MEDIUM;
      end else begin
         step_mode = prce_pkg::MODE_LONG;
      end
      // A new or changed segment starts with its opcode and the previous point.
      if (!seg_open || step_mode != seg_mode) begin
         case (step_mode)
            prce_pkg::MODE_SHORT:  op = short_op;
            prce_pkg::MODE_MEDIUM: op = medium_op;
            default:               op = long_op;
         endcase
         add_byte(op, 1'b1);
         add_coord(prev_x, prev_y);
         seg_open = 1'b1;
         seg_mode = step_mode;
      end
      // Step data in the format of the chosen mode.
      case (step_mode)
         prce_pkg::MODE_SHORT: begin
            b = {adx[3:0], ady[3:0]};
            if (dx < 0) b[7] = 1'b1;
            if (dy < 0) b[3] = 1'b1;
            add_byte(b, 1'b0);
         end
         prce_pkg::MODE_MEDIUM: begin
            b = ady[7:0];
            if (dy < 0) b[7] = 1'b1;
            add_byte(b, 1'b0);
            add_byte(dx[7:0], 1'b0);
         end
         default: begin
            add_coord(px, py);
         end
      endcase
      for (int i = 0; i < run_len; i++) begin
         w = run_buf[i];
         w.last = (i == run_len - 1);
         owed_bytes = {owed_bytes, w};
      end
      prev_x = px;
      prev_y = py;
   endtask

   // Compares one delivered byte with the oldest byte still owed.
   task automatic check_word(input stream_word_type got);
      stream_word_type want;
      bytes_checked++;
      if (owed_bytes.size() == 0) begin
         $display("%0t: unexpected byte: got data %02h opcode %0b last %0b",
                  $time, got.data, got.opcode, got.last);
         error_count++;
         return;
      end
      want = owed_bytes.pop_front();
      if (want !== got) begin
         $display({"%0t: byte mismatch: expected data %02h opcode %0b last %0b,",
                   " got data %02h opcode %0b last %0b"},
                  $time, want.data, want.opcode, want.last,
                  got.data, got.opcode, got.last);
         error_count++;
      end
   endtask

   // Sample all three ports at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         short_op  = prce_pkg::SHORT_OPCODE_RESET;
         medium_op = prce_pkg::MEDIUM_OPCODE_RESET;
         long_op   = prce_pkg::LONG_OPCODE_RESET;
         prev_x    = '0;
         prev_y    = '0;
         have_prev = 1'b0;
         seg_open  = 1'b0;
         seg_mode  = prce_pkg::MODE_SHORT;
         owed_bytes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               prce_pkg::REG_SHORT_OPCODE:  short_op  = csr_pwdata[prce_pkg::BYTE_W-1:0];
               prce_pkg::REG_MEDIUM_OPCODE: medium_op = csr_pwdata[prce_pkg::BYTE_W-1:0];
               prce_pkg::REG_LONG_OPCODE:   long_op   = csr_pwdata[prce_pkg::BYTE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            check_word('{data: rsp_out_byte, opcode: rsp_is_opcode, last: rsp_last_of_run});
         end
         if (req_valid && req_ready) begin
            encode_point(req_point_x, req_point_y, req_starts_polyline);
         end
      end
      bytes_pending = owed_bytes.size();
   end

endmodule

// ===== dv/polyline_relative_coord_encoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline encoder testbench
// Drives points into the encoder with bursty timing and a stalling byte
// receiver, steps through several opcode register settings, and leaves all
// prediction and comparison to the stream checker beside the block.
// ----------------------------------------------------------------------------
module polyline_relative_coord_encoder_top_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BURST = 22;
   localparam int HOLD_CYCLES  = 120;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [prce_pkg::COORD_W-1:0]    req_point_x;
   logic [prce_pkg::COORD_W-1:0]    req_point_y;
   logic                            req_starts_polyline;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [prce_pkg::BYTE_W-1:0]     rsp_out_byte;
   logic                            rsp_is_opcode;
   logic                            rsp_last_of_run;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [prce_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [prce_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [prce_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   int error_count, bytes_pending, points_seen, bytes_checked;
   int cycle_count = 0;
   int burst_left;
   int hold_left;
   int settings_used;
   bit pressure_req;
   bit pressure_done;
   int gen_x, gen_y;

   polyline_relative_coord_encoder_top dut (.*);

   prce_stream_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .req_starts_polyline (req_starts_polyline),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_is_opcode       (rsp_is_opcode),
      .rsp_last_of_run     (rsp_last_of_run),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_pready          (csr_pready),
      .error_count         (error_count),
      .bytes_pending       (bytes_pending),
      .points_seen         (points_seen),
      .bytes_checked       (bytes_checked)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
         $display("polyline_relative_coord_encoder_top_tb: errors");
         $finish;
      end
   end

   // Byte receiver: changes its stall pattern after a random span and, once
   // asked, refuses bytes for a long stretch so the block backs up.
   initial begin
      int style, span;
      hold_left     = 0;
      pressure_done = 1'b0;
      rsp_ready    <= 1'b0;
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(10, 60);
         repeat (span) begin
            @(posedge clock);
            if (hold_left > 0) begin
               rsp_ready <= 1'b0;
               hold_left--;
            end else if (pressure_req && !pressure_done) begin
               pressure_done = 1'b1;
               hold_left     = HOLD_CYCLES;
               rsp_ready    <= 1'b0;
            end else begin
               case (style)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= 1'($urandom_range(0, 1));
                  2: rsp_ready <= ($urandom_range(0, 3) != 0);
                  default: rsp_ready <= ($urandom_range(0, 4) == 0);
               endcase
            end
         end
      end
   end

   // Offers one point, after a gap when a burst has run out, and returns at
   // the edge where the block takes it.
   task automatic send_point(input int px, input int py, input bit first);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            9:       gap = $urandom_range(10, 20);
            default: gap = $urandom_range(1, 4);
         endcase
      end
      if (hold_left > 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_point_x         <= px[prce_pkg::COORD_W-1:0];
      req_point_y         <= py[prce_pkg::COORD_W-1:0];
      req_starts_polyline <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      gen_x = px;
      gen_y = py;
   endtask

   // Picks a step length that tends toward the mode thresholds.
   function automatic int pick_delta(input int kind, input bit vertical);
      int edges[9] = '{0, 6, 7, -7, 127, 128, -128, -110, -111};
      case (kind)
         0, 1, 2, 3: return $urandom_range(0, 12) - 6;
         4, 5, 6:    return vertical ? $urandom_range(0, 237) - 110
                                     : $urandom_range(0, 254) - 127;
         default:    return edges[$urandom_range(0, 8)];
      endcase
   endfunction

   // Keeps a stepped coordinate on the grid by stepping the other way.
   function automatic int step_coord(input int base, input int delta);
      if (base + delta < 0 || base + delta > 4095) return base - delta;
      return base + delta;
   endfunction

   // Random points, mostly polylines with short, medium and threshold steps.
   task automatic send_random_points(input int count);
      int kind, px, py;
      bit first;
      repeat (count) begin
         first = ($urandom_range(0, 99) < 12);
         kind  = $urandom_range(0, 9);
         if (first || kind >= 8) begin
            px = $urandom_range(0, 4095);
            py = $urandom_range(0, 4095);
         end else begin
            px = step_coord(gen_x, pick_delta(kind, 1'b0));
            py = step_coord(gen_y, pick_delta(kind, 1'b1));
         end
         send_point(px, py, first);
      end
   endtask

   // Lets every owed byte come out. The first edge gives the checker time to
   // count the bytes of the point taken last.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle.
   task automatic csr_write(input logic [1:0] index,
                            input logic [prce_pkg::BYTE_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {{(prce_pkg::CSR_DATA_W-prce_pkg::BYTE_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_opcodes(input logic [prce_pkg::BYTE_W-1:0] s_op,
                              input logic [prce_pkg::BYTE_W-1:0] m_op,
                              input logic [prce_pkg::BYTE_W-1:0] l_op);
      csr_write(prce_pkg::REG_SHORT_OPCODE, s_op);
      csr_write(prce_pkg::REG_MEDIUM_OPCODE, m_op);
      csr_write(prce_pkg::REG_LONG_OPCODE, l_op);
      settings_used++;
   endtask

   // Stimulus and verdict.
   initial begin
      burst_left    = 0;
      settings_used = 1;
      pressure_req  = 1'b0;
      gen_x         = 0;
      gen_y         = 0;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_point_x         <= '0;
      req_point_y         <= '0;
      req_starts_polyline <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed points under the reset opcodes. The first has no previous
      // point, then every mode, the thresholds and the coordinate extremes.
      send_point(5, 5, 1'b0);
      send_point(5, 5, 1'b0);          // repeated point is a zero short step
      send_point(11, 11, 1'b0);
      send_point(5, 5, 1'b0);
      send_point(12, 5, 1'b0);         // distance 7 goes medium
      send_point(139, 132, 1'b0);
      send_point(11, 132, 1'b0);       // distance 128 goes long
      send_point(11, 22, 1'b0);        // dy of -110 is still medium
      send_point(11, 4000, 1'b1);
      send_point(11, 3889, 1'b0);      // dy of -111 goes long
      send_point(4095, 4095, 1'b0);
      send_point(0, 0, 1'b0);
      send_point(0, 0, 1'b1);          // a restart closes the open segment
      send_point(0, 1, 1'b0);
      send_point(100, 100, 1'b1);      // lone points emit nothing
      send_point(200, 200, 1'b1);
      send_point(4095, 0, 1'b1);
      send_point(4089, 6, 1'b0);
      send_point(4095, 0, 1'b0);
      send_point(3968, 100, 1'b0);
      send_point(3900, 0, 1'b0);
      send_point(3900, 0, 1'b0);
      send_point(3906, 6, 1'b0);
      drain();

      // Random points under extreme and random opcode settings.
      set_opcodes(8'h00, 8'hff, 8'h01);
      send_random_points(RANDOM_BURST);
      drain();
      set_opcodes(8'hff, 8'h00, 8'hfe);
      send_random_points(RANDOM_BURST);
      drain();
      set_opcodes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      pressure_req = 1'b1;
      send_random_points(RANDOM_BURST);
      drain();
      set_opcodes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      send_random_points(RANDOM_BURST);
      drain();

      $display("Encoded %0d points into %0d checked bytes over %0d opcode settings,",
               points_seen, bytes_checked, settings_used);
      $display("with bursty input, random output stalls and one long receiver hold-off.");
      if (error_count == 0) begin
         $display("polyline_relative_coord_encoder_top_tb: clean");
      end else begin
         $display("polyline_relative_coord_encoder_top_tb: errors");
      end
      $finish;
   end

endmodule

// ===== polyline_relative_coord_encoder_top.f =====
rtl/prce_pkg.sv
rtl/prce_step.sv
rtl/polyline_relative_coord_encoder_top.sv
dv/prce_stream_checker.sv
dv/polyline_relative_coord_encoder_top_tb.sv
